// ----- design/b64sc_pkg.sv -----
// Shared types, constants and alphabet functions for the base64 stream codec.
package b64sc_pkg;

  // Register value of decode_mode.
  localparam logic MODE_ENCODE = 1'b0;
  localparam logic MODE_DECODE = 1'b1;

  // Largest number of result beats one input beat can cause.
  localparam int MAX_RES   = 4;
  localparam int RES_CNT_W = $clog2(MAX_RES + 1);
  localparam int RES_IDX_W = $clog2(MAX_RES);

  // Character codes and the extra decode codes beyond the 6-bit value range.
  localparam logic [7:0] PAD_CHAR       = 8'h3D;
  localparam logic [6:0] SEXTET_INVALID = 7'd64;
  localparam logic [6:0] SEXTET_PAD     = 7'd65;

  // Per-message state.
  typedef struct packed {
    logic [1:0] pos;
    logic [5:0] lo;
    logic       pad;
    logic       err;
  } b64sc_state_t;

  // One result beat.
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       err;
    logic       vld;
  } b64sc_res_t;

  typedef b64sc_res_t [MAX_RES-1:0] b64sc_res_list_t;

  // Map a 6-bit value to its alphabet character.
  function automatic logic [7:0] to_char(input logic [5:0] v);
    logic [7:0] w;
    w = {2'b00, v};
    if (v < 6'd26)       return w + 8'h41;
    else if (v < 6'd52)  return w + 8'h47;
    else if (v < 6'd62)  return w - 8'h04;
    else if (v == 6'd62) return 8'h2B;
    else                 return 8'h2F;
  endfunction

  // Map a character to its 6-bit value, the pad code or the invalid code.
  function automatic logic [6:0] from_char(input logic [7:0] c);
    logic [7:0] d;
    d = 8'h00;
    if (c >= 8'h41 && c <= 8'h5A) begin
      d = c - 8'h41;
      return {1'b0, d[5:0]};
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      d = c - 8'h47;
      return {1'b0, d[5:0]};
    end else if (c >= 8'h30 && c <= 8'h39) begin
      d = c + 8'h04;
      return {1'b0, d[5:0]};
    end else if (c == 8'h2B) begin
      return 7'd62;
    end else if (c == 8'h2F) begin
      return 7'd63;
    end else if (c == PAD_CHAR) begin
      return SEXTET_PAD;
    end else begin
      return SEXTET_INVALID;
    end
  endfunction

endpackage

// ----- design/base64_stream_codec.sv -----
// Top level of the base64 stream codec: input register, result buffer, output register.
//
// Usage: write decode_mode on the cfg channel while the block is idle (0 encodes
// bytes to base64 characters, 1 decodes characters to bytes); each write also
// clears the message state. Input beats carry one byte in in_tdata and in_tlast
// on the final byte of a message. Output beats carry a character or data byte in
// out_tdata, out_tlast on the final result of the message, and flags in out_tuser.
// An accepted beat passes the input register, the result buffer and then the output
// register. Throughput: one result beat per cycle while the receiver does not stall;
// ordinary encode bytes give one or two characters, a last byte up to four. A decode
// beat that gives no result leaves the result buffer free for the next beat. The
// input register takes the next beat while results of the previous one are still
// draining. When the receiver stalls, the output register holds its beat, the buffer
// stops draining, and in_tready drops once the input register is full. Reset selects
// encode mode and clears the message state, the input and output valid flags and the
// result buffer count.
module base64_stream_codec
  import b64sc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  // Configuration channel
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_data,    // decode_mode
  // Input stream
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,    // [7:0] in_byte
  input  logic       in_tlast,
  // Result stream
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,   // [7:0] out_byte
  output logic       out_tlast,
  output logic [1:0] out_tuser    // [0] out_error, [1] out_valid_data
);

  logic                 mode_r, mode_nxt;
  b64sc_state_t         st_r, st_nxt, step_st;
  logic                 in_vld_r, in_vld_nxt;
  logic [7:0]           in_byte_r, in_byte_nxt;
  logic                 in_last_r, in_last_nxt;
  b64sc_res_list_t      buf_r, buf_nxt, step_res;
  logic [RES_CNT_W-1:0] cnt_r, cnt_nxt, step_cnt;
  logic [RES_IDX_W-1:0] idx_r, idx_nxt;
  logic                 out_vld_r, out_vld_nxt;
  b64sc_res_t           out_r, out_nxt;
  logic                 pop;
  logic                 take;

  b64sc_step u_step (
    .mode    (mode_r),
    .st      (st_r),
    .in_byte (in_byte_r),
    .in_last (in_last_r),
    .st_nxt  (step_st),
    .res     (step_res),
    .res_cnt (step_cnt)
  );

  // Handshake control.
  assign cfg_ready = 1'b1;
  assign pop       = (cnt_r != '0) && (!out_vld_r || out_tready);
  assign take      = in_vld_r && ((cnt_r == '0) || ((cnt_r == RES_CNT_W'(1)) && pop));
  assign in_tready = !in_vld_r || take;

  // Next-state logic for configuration, input register, buffer and output register.
  always_comb begin
    mode_nxt    = mode_r;
    st_nxt      = st_r;
    in_vld_nxt  = in_vld_r;
    in_byte_nxt = in_byte_r;
    in_last_nxt = in_last_r;
    buf_nxt     = buf_r;
    cnt_nxt     = cnt_r;
    idx_nxt     = idx_r;
    out_vld_nxt = out_vld_r;
    out_nxt     = out_r;

    // Input register.
    if (in_tready) begin
      in_vld_nxt  = in_tvalid;
      in_byte_nxt = in_tdata;
      in_last_nxt = in_tlast;
    end

    // Result buffer: load a full result list or drain one beat.
    if (take) begin
      buf_nxt = step_res;
      cnt_nxt = step_cnt;
      idx_nxt = '0;
      st_nxt  = step_st;
    end else if (pop) begin
      cnt_nxt = cnt_r - RES_CNT_W'(1);
      idx_nxt = idx_r + RES_IDX_W'(1);
    end

    // Output register.
    if (pop) begin
      out_vld_nxt = 1'b1;
      out_nxt     = buf_r[idx_r];
    end else if (out_tready) begin
      out_vld_nxt = 1'b0;
    end

    // Configuration write selects the mode and restarts the message.
    if (cfg_valid) begin
      mode_nxt = cfg_data;
      st_nxt   = '0;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= MODE_ENCODE;
      st_r      <= '0;
      in_vld_r  <= 1'b0;
      cnt_r     <= '0;
      idx_r     <= '0;
      out_vld_r <= 1'b0;
    end else begin
      mode_r    <= mode_nxt;
      st_r      <= st_nxt;
      in_vld_r  <= in_vld_nxt;
      cnt_r     <= cnt_nxt;
      idx_r     <= idx_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    in_byte_r <= in_byte_nxt;
    in_last_r <= in_last_nxt;
    buf_r     <= buf_nxt;
    out_r     <= out_nxt;
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_r.data;
  assign out_tlast  = out_r.last;
  assign out_tuser  = {out_r.vld, out_r.err};

endmodule

// ----- design/b64sc_step.sv -----
// Combinational encode/decode step: one input beat to its result list and next state.
module b64sc_step
  import b64sc_pkg::*;
(
  input  logic                 mode,
  input  b64sc_state_t         st,
  input  logic [7:0]           in_byte,
  input  logic                 in_last,
  output b64sc_state_t         st_nxt,
  output b64sc_res_list_t      res,
  output logic [RES_CNT_W-1:0] res_cnt
);

  logic [6:0] code;
  logic [5:0] v;
  logic [7:0] dec_data;
  logic       have;
  logic       fail;
  b64sc_state_t s;

  assign code = from_char(in_byte);
  assign v    = code[5:0];

  always_comb begin
    s        = st;
    res      = '0;
    res_cnt  = '0;
    have     = 1'b0;
    dec_data = 8'h00;
    fail     = 1'b0;
    if (mode == MODE_ENCODE) begin
      // Encode: one or two characters from this byte, then an optional flush.
      case (st.pos)
        2'd0: begin
          res[0] = '{data: to_char(in_byte[7:2]), last: 1'b0, err: 1'b0, vld: 1'b1};
          s.lo   = {4'b0000, in_byte[1:0]};
          s.pos  = 2'd1;
          res_cnt = RES_CNT_W'(1);
        end
        2'd1: begin
          res[0] = '{data: to_char({st.lo[1:0], in_byte[7:4]}),
                     last: 1'b0, err: 1'b0, vld: 1'b1};
          s.lo   = {2'b00, in_byte[3:0]};
          s.pos  = 2'd2;
          res_cnt = RES_CNT_W'(1);
        end
        default: begin
          res[0] = '{data: to_char({st.lo[3:0], in_byte[7:6]}),
                     last: 1'b0, err: 1'b0, vld: 1'b1};
          res[1] = '{data: to_char(in_byte[5:0]), last: 1'b0, err: 1'b0, vld: 1'b1};
          s.lo   = '0;
          s.pos  = 2'd0;
          res_cnt = RES_CNT_W'(2);
        end
      endcase
      if (in_last) begin
        // A flush only follows a single character, so it fills slots one up.
        if (s.pos == 2'd1) begin
          res[1] = '{data: to_char({s.lo[1:0], 4'b0000}), last: 1'b0, err: 1'b0, vld: 1'b1};
          res[2] = '{data: PAD_CHAR, last: 1'b0, err: 1'b0, vld: 1'b1};
          res[3] = '{data: PAD_CHAR, last: 1'b1, err: 1'b0, vld: 1'b1};
          res_cnt = RES_CNT_W'(4);
        end else if (s.pos == 2'd2) begin
          res[1] = '{data: to_char({s.lo[3:0], 2'b00}), last: 1'b0, err: 1'b0, vld: 1'b1};
          res[2] = '{data: PAD_CHAR, last: 1'b1, err: 1'b0, vld: 1'b1};
          res_cnt = RES_CNT_W'(3);
        end else begin
          res[1].last = 1'b1;
        end
        s = '0;
      end
    end else begin
      // Decode: update the sextet accumulator unless the message already failed.
      if (!st.err) begin
        if (code == SEXTET_INVALID) begin
          s.err = 1'b1;
        end else if (code == SEXTET_PAD) begin
          if (st.pos < 2'd2) begin
            s.err = 1'b1;
          end else begin
            s.pad = 1'b1;
            s.pos = st.pos + 2'd1;
            s.lo  = '0;
          end
        end else if (st.pad) begin
          s.err = 1'b1;
        end else begin
          case (st.pos)
            2'd0: begin
              s.lo = v;
            end
            2'd1: begin
              dec_data = {st.lo, v[5:4]};
              s.lo     = {2'b00, v[3:0]};
              have     = 1'b1;
            end
            2'd2: begin
              dec_data = {st.lo[3:0], v[5:2]};
              s.lo     = {4'b0000, v[1:0]};
              have     = 1'b1;
            end
            default: begin
              dec_data = {st.lo[1:0], v};
              s.lo     = '0;
              have     = 1'b1;
            end
          endcase
          s.pos = st.pos + 2'd1;
        end
      end
      if (in_last) begin
        // End of message: data beat (if any), then an error or end marker if needed.
        fail = s.err || (s.pos != 2'd0);
        if (have) begin
          res[0] = '{data: dec_data, last: !fail, err: 1'b0, vld: 1'b1};
          if (fail) begin
            res[1]  = '{data: 8'h00, last: 1'b1, err: 1'b1, vld: 1'b0};
            res_cnt = RES_CNT_W'(2);
          end else begin
            res_cnt = RES_CNT_W'(1);
          end
        end else begin
          res[0]  = '{data: 8'h00, last: 1'b1, err: fail, vld: 1'b0};
          res_cnt = RES_CNT_W'(1);
        end
        s = '0;
      end else if (have) begin
        res[0]  = '{data: dec_data, last: 1'b0, err: 1'b0, vld: 1'b1};
        res_cnt = RES_CNT_W'(1);
      end
    end
    st_nxt = s;
  end

endmodule
